// File: hw/rtl/lslc_pkg.sv
// ----------------------------------------------------------------------------
// lslc_pkg
// Shared widths, register indexes and types of the layered sprite list culler.
// ----------------------------------------------------------------------------
`default_nettype none

package lslc_pkg;

	// Default sizes of the sprite store and the layer directory
	localparam int unsigned DEF_MAX_SPRITES = 64;
	localparam int unsigned DEF_MAX_LAYERS  = 16;

	// Fixed field widths
	localparam int unsigned COORD_W    = 32;
	localparam int unsigned HANDLE_W   = 16;
	localparam int unsigned LAYER_W    = 8;
	localparam int unsigned SIZE_W     = 16;
	localparam int unsigned LCOUNT_W   = 5;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_LEFT   = 3'd0,
		REG_VIEW_TOP    = 3'd1,
		REG_VIEW_WIDTH  = 3'd2,
		REG_VIEW_HEIGHT = 3'd3,
		REG_LAYERS      = 3'd4
	} cfg_reg_t;

	// Result of one pass through the axis window unit
	typedef struct packed {
		logic                      hit;
		logic signed [COORD_W-1:0] screen;
	} axis_res_t;

	// Layer directory controls
	typedef struct packed {
		logic add;    // append a sprite to a layer
		logic look;   // read head, tail and occupancy of the walked layer
		logic clear;  // mark the walked layer empty
	} dir_ctl_t;

	// Sprite store controls
	typedef struct packed {
		logic wr;     // write a new entry
		logic link;   // write a next pointer
		logic rd;     // read one entry
	} store_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/lslc_if.sv
// ----------------------------------------------------------------------------
// lslc_in_if / lslc_out_if
// Valid/ready channels for sprite commands and culled frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lslc_in_if import lslc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic signed [COORD_W-1:0]  image_x;
	logic signed [COORD_W-1:0]  image_y;
	logic        [HANDLE_W-1:0] image_handle;
	logic        [LAYER_W-1:0]  layer;

	modport source (
		output valid, func, image_x, image_y, image_handle, layer,
		input  ready
	);

	modport sink (
		input  valid, func, image_x, image_y, image_handle, layer,
		output ready
	);
endinterface

interface lslc_out_if import lslc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       visible;
	logic        [HANDLE_W-1:0] out_handle;
	logic signed [COORD_W-1:0]  screen_x;
	logic signed [COORD_W-1:0]  screen_y;
	logic                       last;

	modport source (
		output valid, visible, out_handle, screen_x, screen_y, last,
		input  ready
	);

	modport sink (
		input  valid, visible, out_handle, screen_x, screen_y, last,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/lslc_axis_unit.sv
// ----------------------------------------------------------------------------
// lslc_axis_unit
// Shared window unit: tests one coordinate against the culling window of one
// axis and forms the saturated screen coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module lslc_axis_unit import lslc_pkg::*; (
	input  logic signed [COORD_W-1:0] coord,
	input  logic signed [COORD_W-1:0] origin,
	input  logic        [SIZE_W-1:0]  size,
	output axis_res_t                 res
);

	logic signed [COORD_W:0]   diff;
	logic signed [COORD_W+1:0] lo_sum;
	logic signed [COORD_W+1:0] hi_sum;

	// Exact offset from the view origin
	assign diff = $signed({coord[COORD_W-1], coord}) - $signed({origin[COORD_W-1], origin});

	// Window is -size <= diff <= 2*size
	assign lo_sum = $signed({diff[COORD_W], diff}) + $signed({18'd0, size});
	assign hi_sum = $signed({17'd0, size, 1'b0}) - $signed({diff[COORD_W], diff});

	// Flag a hit and clamp the offset to the signed 32-bit range
	always_comb begin
		res.hit = !lo_sum[COORD_W+1] && !hi_sum[COORD_W+1];
		if (diff[COORD_W] != diff[COORD_W-1]) begin
			res.screen = diff[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
				: {1'b0, {(COORD_W-1){1'b1}}};
		end else begin
			res.screen = diff[COORD_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lslc_sprite_store.sv
// ----------------------------------------------------------------------------
// lslc_sprite_store
// Sprite memories: position, image handle and the next link of each entry.
// One entry write, one link write and one registered entry read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lslc_sprite_store import lslc_pkg::*; #(
	parameter  int unsigned MAX_SPRITES = DEF_MAX_SPRITES,
	localparam int unsigned SW = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1
) (
	input  logic                       clk,
	input  store_ctl_t                 ctl,
	input  logic        [SW-1:0]       wr_idx,
	input  logic signed [COORD_W-1:0]  wr_x,
	input  logic signed [COORD_W-1:0]  wr_y,
	input  logic        [HANDLE_W-1:0] wr_handle,
	input  logic        [SW-1:0]       link_idx,
	input  logic        [SW-1:0]       link_val,
	input  logic        [SW-1:0]       rd_idx,
	output logic signed [COORD_W-1:0]  rd_x,
	output logic signed [COORD_W-1:0]  rd_y,
	output logic        [HANDLE_W-1:0] rd_handle,
	output logic        [SW-1:0]       rd_next
);

	logic [COORD_W-1:0]  x_mem      [MAX_SPRITES];
	logic [COORD_W-1:0]  y_mem      [MAX_SPRITES];
	logic [HANDLE_W-1:0] handle_mem [MAX_SPRITES];
	logic [SW-1:0]       next_mem   [MAX_SPRITES];

	// Store new entries
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			x_mem[wr_idx]      <= wr_x;
			y_mem[wr_idx]      <= wr_y;
			handle_mem[wr_idx] <= wr_handle;
		end
	end

	// Chain an entry behind the old tail of its layer
	always_ff @(posedge clk) begin
		if (ctl.link) begin
			next_mem[link_idx] <= link_val;
		end
	end

	// Registered read of one entry
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_x      <= x_mem[rd_idx];
			rd_y      <= y_mem[rd_idx];
			rd_handle <= handle_mem[rd_idx];
			rd_next   <= next_mem[rd_idx];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lslc_layer_dir.sv
// ----------------------------------------------------------------------------
// lslc_layer_dir
// Layer directory: head and tail entry of each layer list plus an occupancy
// bit per layer that reset clears.
// ----------------------------------------------------------------------------
`default_nettype none

module lslc_layer_dir import lslc_pkg::*; #(
	parameter  int unsigned MAX_SPRITES = DEF_MAX_SPRITES,
	parameter  int unsigned MAX_LAYERS  = DEF_MAX_LAYERS,
	localparam int unsigned SW = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1,
	localparam int unsigned LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dir_ctl_t      ctl,
	input  logic [LW-1:0] add_layer,
	input  logic [SW-1:0] add_idx,
	input  logic [LW-1:0] walk_layer,
	output logic          need_link,
	output logic          nonempty,
	output logic [SW-1:0] head_idx,
	output logic [SW-1:0] tail_idx
);

	logic [MAX_LAYERS-1:0] valid_q;
	logic [SW-1:0]         head_mem [MAX_LAYERS];
	logic [SW-1:0]         tail_mem [MAX_LAYERS];
	logic [LW-1:0]         tail_addr;

	assign tail_addr = ctl.add ? add_layer : walk_layer;

	// Track which layers hold sprites
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			need_link <= 1'b0;
			nonempty  <= 1'b0;
		end else begin
			if (ctl.add) begin
				valid_q[add_layer] <= 1'b1;
				need_link          <= valid_q[add_layer];
			end
			if (ctl.look) begin
				nonempty <= valid_q[walk_layer];
			end
			if (ctl.clear) begin
				valid_q[walk_layer] <= 1'b0;
			end
		end
	end

	// Head and tail tables; the old tail comes out when a sprite is appended
	always_ff @(posedge clk) begin
		if (ctl.add && !valid_q[add_layer]) begin
			head_mem[add_layer] <= add_idx;
		end
		if (ctl.add) begin
			tail_mem[add_layer] <= add_idx;
		end
		if (ctl.add || ctl.look) begin
			tail_idx <= tail_mem[tail_addr];
		end
		if (ctl.look) begin
			head_idx <= head_mem[walk_layer];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/layered_sprite_list_culler.sv
// Add item: stored, no result. Draw item: walks every layer and reads the stored
// sprites one at a time, and waits while the result side stalls; paced by the single
// read port of the sprite store and the one axis window unit (x then y).
// One item at a time; a finished result waits in an output register.
// Reset: view registers zero, layer count one, all layers empty, store empty;
// no clearing pass.
// ----------------------------------------------------------------------------
// layered_sprite_list_culler
// Sprite display list with per-layer linked lists; a draw walks the layers in
// order, culls each sprite against the view window and empties the store.
// ----------------------------------------------------------------------------
`default_nettype none

module layered_sprite_list_culler import lslc_pkg::*; #(
	parameter  int unsigned MAX_SPRITES = DEF_MAX_SPRITES,
	parameter  int unsigned MAX_LAYERS  = DEF_MAX_LAYERS,
	localparam int unsigned SW = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1,
	localparam int unsigned CW = $clog2(MAX_SPRITES + 1),
	localparam int unsigned LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lslc_in_if.sink               sprite_in,
	lslc_out_if.source            frame_out
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_ADD2  = 9'b000000010,
		S_LAYER = 9'b000000100,
		S_HEAD  = 9'b000001000,
		S_FETCH = 9'b000010000,
		S_AXX   = 9'b000100000,
		S_AXY   = 9'b001000000,
		S_FIN   = 9'b010000000,
		S_SPARE = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	// Configuration
	logic signed [COORD_W-1:0]  view_left_q;
	logic signed [COORD_W-1:0]  view_top_q;
	logic        [SIZE_W-1:0]   view_width_q;
	logic        [SIZE_W-1:0]   view_height_q;
	logic        [LCOUNT_W-1:0] layers_q;

	// Walk state
	logic [CW-1:0] count_q;
	logic [LW-1:0] layer_q;
	logic [SW-1:0] ptr_q;
	logic          hx_q;
	logic signed [COORD_W-1:0] sx_q;

	// Pending visible sprite, held until the next one shows whether it is last
	logic                       pend_v_q;
	logic        [HANDLE_W-1:0] pend_handle_q;
	logic signed [COORD_W-1:0]  pend_x_q;
	logic signed [COORD_W-1:0]  pend_y_q;

	// Output register
	logic                       out_v_q;
	logic                       out_vis_q;
	logic        [HANDLE_W-1:0] out_handle_q;
	logic signed [COORD_W-1:0]  out_x_q;
	logic signed [COORD_W-1:0]  out_y_q;
	logic                       out_last_q;

	// Submodule connections
	dir_ctl_t      dir_ctl;
	store_ctl_t    st_ctl;
	logic          dir_need_link;
	logic          dir_nonempty;
	logic [SW-1:0] dir_head;
	logic [SW-1:0] dir_tail;
	logic signed [COORD_W-1:0]  rd_x;
	logic signed [COORD_W-1:0]  rd_y;
	logic        [HANDLE_W-1:0] rd_handle;
	logic        [SW-1:0]       rd_next;
	logic signed [COORD_W-1:0]  ax_coord;
	logic signed [COORD_W-1:0]  ax_origin;
	logic        [SIZE_W-1:0]   ax_size;
	axis_res_t                  ax_res;

	logic          accept;
	logic          full;
	logic [7:0]    n_eff;
	logic [7:0]    li8;
	logic [LW-1:0] add_layer;
	logic          out_free;
	logic          vis;
	logic          stall;
	logic          layer_last;
	logic          load_out;
	logic          load_vis;
	logic          load_last;
	logic [HANDLE_W-1:0]       load_handle;
	logic signed [COORD_W-1:0] load_x;
	logic signed [COORD_W-1:0] load_y;

	assign sprite_in.ready = (state_q == S_IDLE);
	assign accept          = sprite_in.valid && sprite_in.ready;
	assign full            = (count_q == CW'(MAX_SPRITES));
	assign out_free        = !out_v_q || frame_out.ready;
	assign layer_last      = (layer_q == LW'(MAX_LAYERS - 1));

	assign frame_out.valid      = out_v_q;
	assign frame_out.visible    = out_vis_q;
	assign frame_out.out_handle = out_handle_q;
	assign frame_out.screen_x   = out_x_q;
	assign frame_out.screen_y   = out_y_q;
	assign frame_out.last       = out_last_q;

	// Clamp the one-based layer number into the layers in use
	always_comb begin
		n_eff = {3'd0, layers_q};
		if (n_eff == 8'd0) begin
			n_eff = 8'd1;
		end
		if (n_eff > 8'(MAX_LAYERS)) begin
			n_eff = 8'(MAX_LAYERS);
		end
		li8 = (sprite_in.layer == 8'd0) ? 8'd0 : sprite_in.layer - 8'd1;
		if (li8 >= n_eff) begin
			li8 = n_eff - 8'd1;
		end
	end
	assign add_layer = li8[LW-1:0];

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_left_q   <= '0;
			view_top_q    <= '0;
			view_width_q  <= '0;
			view_height_q <= '0;
			layers_q      <= LCOUNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_VIEW_LEFT: begin
					view_left_q <= cfg_data;
				end
				REG_VIEW_TOP: begin
					view_top_q <= cfg_data;
				end
				REG_VIEW_WIDTH: begin
					view_width_q <= cfg_data[SIZE_W-1:0];
				end
				REG_VIEW_HEIGHT: begin
					view_height_q <= cfg_data[SIZE_W-1:0];
				end
				REG_LAYERS: begin
					layers_q <= cfg_data[LCOUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Feed the shared window unit: x axis first, then y axis
	always_comb begin
		if (state_q == S_AXY) begin
			ax_coord  = rd_y;
			ax_origin = view_top_q;
			ax_size   = view_height_q;
		end else begin
			ax_coord  = rd_x;
			ax_origin = view_left_q;
			ax_size   = view_width_q;
		end
	end

	assign vis   = (state_q == S_AXY) && hx_q && ax_res.hit;
	assign stall = vis && pend_v_q && !out_free;

	// Sequencer
	always_comb begin
		state_d     = state_q;
		dir_ctl     = '0;
		st_ctl      = '0;
		load_out    = 1'b0;
		load_vis    = 1'b1;
		load_last   = 1'b0;
		load_handle = pend_handle_q;
		load_x      = pend_x_q;
		load_y      = pend_y_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (sprite_in.func) begin
						state_d = S_LAYER;
					end else if (!full) begin
						dir_ctl.add = 1'b1;
						st_ctl.wr   = 1'b1;
						state_d     = S_ADD2;
					end
				end
			end
			S_ADD2: begin
				st_ctl.link = dir_need_link;
				state_d     = S_IDLE;
			end
			S_LAYER: begin
				dir_ctl.look = 1'b1;
				state_d      = S_HEAD;
			end
			S_HEAD: begin
				if (dir_nonempty) begin
					state_d = S_FETCH;
				end else begin
					dir_ctl.clear = 1'b1;
					state_d       = layer_last ? S_FIN : S_LAYER;
				end
			end
			S_FETCH: begin
				st_ctl.rd = 1'b1;
				state_d   = S_AXX;
			end
			S_AXX: begin
				state_d = S_AXY;
			end
			S_AXY: begin
				if (!stall) begin
					load_out = vis && pend_v_q;
					if (ptr_q == dir_tail) begin
						dir_ctl.clear = 1'b1;
						state_d       = layer_last ? S_FIN : S_LAYER;
					end else begin
						state_d = S_FETCH;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					load_out  = 1'b1;
					load_last = 1'b1;
					if (!pend_v_q) begin
						load_vis    = 1'b0;
						load_handle = '0;
						load_x      = '0;
						load_y      = '0;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			layer_q  <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ADD2) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == S_FIN && out_free) begin
				count_q  <= '0;
				pend_v_q <= 1'b0;
			end
			if (accept && sprite_in.func) begin
				layer_q <= '0;
			end else if (dir_ctl.clear && !layer_last) begin
				layer_q <= layer_q + LW'(1);
			end
			if (vis && !stall) begin
				pend_v_q <= 1'b1;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (frame_out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Walk pointer, axis result and result payloads
	always_ff @(posedge clk) begin
		if (state_q == S_HEAD) begin
			ptr_q <= dir_head;
		end else if (state_q == S_AXY && !stall) begin
			ptr_q <= rd_next;
		end
		if (state_q == S_AXX) begin
			hx_q <= ax_res.hit;
			sx_q <= ax_res.screen;
		end
		if (vis && !stall) begin
			pend_handle_q <= rd_handle;
			pend_x_q      <= sx_q;
			pend_y_q      <= ax_res.screen;
		end
		if (load_out) begin
			out_vis_q    <= load_vis;
			out_handle_q <= load_handle;
			out_x_q      <= load_x;
			out_y_q      <= load_y;
			out_last_q   <= load_last;
		end
	end

	lslc_layer_dir #(
		.MAX_SPRITES (MAX_SPRITES),
		.MAX_LAYERS  (MAX_LAYERS)
	) u_dir (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (dir_ctl),
		.add_layer  (add_layer),
		.add_idx    (count_q[SW-1:0]),
		.walk_layer (layer_q),
		.need_link  (dir_need_link),
		.nonempty   (dir_nonempty),
		.head_idx   (dir_head),
		.tail_idx   (dir_tail)
	);

	lslc_sprite_store #(
		.MAX_SPRITES (MAX_SPRITES)
	) u_store (
		.clk       (clk),
		.ctl       (st_ctl),
		.wr_idx    (count_q[SW-1:0]),
		.wr_x      (sprite_in.image_x),
		.wr_y      (sprite_in.image_y),
		.wr_handle (sprite_in.image_handle),
		.link_idx  (dir_tail),
		.link_val  (count_q[SW-1:0]),
		.rd_idx    (ptr_q),
		.rd_x      (rd_x),
		.rd_y      (rd_y),
		.rd_handle (rd_handle),
		.rd_next   (rd_next)
	);

	lslc_axis_unit u_axis (
		.coord  (ax_coord),
		.origin (ax_origin),
		.size   (ax_size),
		.res    (ax_res)
	);

`ifndef SYNTHESIS
	// The closing result of a draw carries the last flag and empties the store
	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (out_v_q && out_last_q && count_q == '0))
		else $error("draw closed without a last result");

	// Store fill never passes its depth
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SPRITES))
		else $error("sprite count beyond store depth");

	// A blocked visible sprite keeps the walk in place with its predecessor held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (state_q == S_AXY && pend_v_q && $stable(ptr_q)))
		else $error("walk advanced while result side stalled");
`endif

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the layered sprite list culler. Stores sprites,
// draws frames and predicts the culled, layer-ordered result stream in a
// behavioral model. Each result is checked field by field as it leaves the
// block. Covers window edges, coordinate extremes, layer clamping, store
// overflow, back-pressure and random traffic under several idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import lslc_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 48;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 5;
	localparam int MAX_SPR        = DEF_MAX_SPRITES;
	localparam int MAX_LAY        = DEF_MAX_LAYERS;
	localparam int REPORT_LIMIT   = 10;

	localparam logic signed [COORD_W-1:0] S32_TOP    = 32'sh7FFFFFFF;
	localparam logic signed [COORD_W-1:0] S32_BOTTOM = 32'sh80000000;
	localparam longint S32_MAX_L = 64'sd2147483647;
	localparam longint S32_MIN_L = -64'sd2147483648;

	typedef enum logic {
		FUNC_ADD  = 1'b0,
		FUNC_DRAW = 1'b1
	} sprite_func_t;

	typedef struct packed {
		logic                      visible;
		logic [HANDLE_W-1:0]       handle;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic                      last;
	} frame_res_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [HANDLE_W-1:0]       handle;
		logic [5:0]                lidx;
	} sprite_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lslc_in_if  sprite_in ();
	lslc_out_if frame_out ();

	layered_sprite_list_culler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sprite_in (sprite_in),
		.frame_out (frame_out)
	);

	// Shadow of the view registers and the sprite store
	logic signed [COORD_W-1:0] view_left_q;
	logic signed [COORD_W-1:0] view_top_q;
	logic [SIZE_W-1:0]         view_width_q;
	logic [SIZE_W-1:0]         view_height_q;
	logic [LCOUNT_W-1:0]       layer_count_q;
	sprite_t                   stored_sprites[$];
	frame_res_t                pending_frames[$];

	// Idling mix and receiver hold-off
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int          hold_request;
	int          hold_left;

	// Run statistics
	int items_taken;
	int draws_taken;
	int results_seen;
	int markers_seen;
	int reg_writes;
	int failures;

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic signed [COORD_W-1:0] clamp32(longint v);
		if (v > S32_MAX_L) v = S32_MAX_L;
		if (v < S32_MIN_L) v = S32_MIN_L;
		return v[COORD_W-1:0];
	endfunction

	// Map a one-based layer number onto the layers in use
	function automatic int unsigned target_layer(logic [LAYER_W-1:0] lay);
		int unsigned n;
		int unsigned li;
		n = layer_count_q;
		if (n < 1) n = 1;
		if (n > MAX_LAY) n = MAX_LAY;
		li = (lay == 0) ? 0 : lay - 1;
		if (li >= n) li = n - 1;
		return li;
	endfunction

	function automatic void store_sprite(logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic [HANDLE_W-1:0] h,
			logic [LAYER_W-1:0] lay);
		sprite_t s;
		if (stored_sprites.size() >= MAX_SPR) return;
		s.x = x;
		s.y = y;
		s.handle = h;
		s.lidx = 6'(target_layer(lay));
		stored_sprites.push_back(s);
	endfunction

	// Walk layers low to high, insertion order within a layer, and empty the store
	function automatic void cull_frame();
		longint     xlo, xhi, ylo, yhi, x, y;
		frame_res_t held, r;
		logic       have;
		int         found;
		xlo = longint'(view_left_q) - longint'(view_width_q);
		xhi = longint'(view_left_q) + 2 * longint'(view_width_q);
		ylo = longint'(view_top_q) - longint'(view_height_q);
		yhi = longint'(view_top_q) + 2 * longint'(view_height_q);
		found = 0;
		have = 1'b0;
		held = '0;
		for (int l = 0; l < MAX_LAY; l++) begin
			foreach (stored_sprites[i]) begin
				if (stored_sprites[i].lidx == l) begin
					x = longint'(stored_sprites[i].x);
					y = longint'(stored_sprites[i].y);
					if (x >= xlo && x <= xhi && y >= ylo && y <= yhi && found < MAX_SPR) begin
						r.visible = 1'b1;
						r.handle = stored_sprites[i].handle;
						r.sx = clamp32(x - longint'(view_left_q));
						r.sy = clamp32(y - longint'(view_top_q));
						r.last = 1'b0;
						if (have) pending_frames.push_back(held);
						held = r;
						have = 1'b1;
						found++;
					end
				end
			end
		end
		// Nothing visible: one empty-frame marker
		if (!have) held = '0;
		held.last = 1'b1;
		pending_frames.push_back(held);
		stored_sprites.delete();
	endfunction

	function automatic void note_mismatch(string what, frame_res_t want, frame_res_t got);
		failures++;
		if (failures <= REPORT_LIMIT) begin
			$display("%0t mismatch (%s): expected vis=%0b h=%h x=%0d y=%0d last=%0b",
				$realtime, what, want.visible, want.handle, want.sx, want.sy, want.last);
			$display("%0t          got      vis=%0b h=%h x=%0d y=%0d last=%0b",
				$realtime, got.visible, got.handle, got.sx, got.sy, got.last);
		end
	endfunction

	// Check results, then track accepted items and register writes
	always @(posedge clk) begin : result_check
		frame_res_t got, want;
		string      bad;
		if (arst_n) begin
			if (frame_out.valid && frame_out.ready) begin
				got.visible = frame_out.visible;
				got.handle = frame_out.out_handle;
				got.sx = frame_out.screen_x;
				got.sy = frame_out.screen_y;
				got.last = frame_out.last;
				results_seen++;
				if (got.visible === 1'b0) markers_seen++;
				if (pending_frames.size() == 0) begin
					note_mismatch("no result expected", '0, got);
				end else begin
					want = pending_frames.pop_front();
					bad = "";
					if (got.visible !== want.visible) bad = {bad, " visible"};
					if (got.handle !== want.handle) bad = {bad, " out_handle"};
					if (got.sx !== want.sx) bad = {bad, " screen_x"};
					if (got.sy !== want.sy) bad = {bad, " screen_y"};
					if (got.last !== want.last) bad = {bad, " last"};
					if (bad != "") note_mismatch(bad, want, got);
				end
			end
			if (sprite_in.valid && sprite_in.ready) begin
				items_taken++;
				if (sprite_in.func == FUNC_DRAW) begin
					draws_taken++;
					cull_frame();
				end else begin
					store_sprite(sprite_in.image_x, sprite_in.image_y,
						sprite_in.image_handle, sprite_in.layer);
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_VIEW_LEFT:   view_left_q = cfg_data;
					REG_VIEW_TOP:    view_top_q = cfg_data;
					REG_VIEW_WIDTH:  view_width_q = cfg_data[SIZE_W-1:0];
					REG_VIEW_HEIGHT: view_height_q = cfg_data[SIZE_W-1:0];
					REG_LAYERS:      layer_count_q = cfg_data[LCOUNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Drive result-side ready: long hold-off on request, else random stalls
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			frame_out.ready = 1'b0;
		end else begin
			frame_out.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sprite_in.valid && sprite_in.ready) || (frame_out.valid && frame_out.ready)
					|| cfg_we || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no handshake in %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, pending_frames.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// Offer one item, with random idle cycles first; return once accepted
	task automatic send_item(sprite_func_t f, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic [HANDLE_W-1:0] h, logic [LAYER_W-1:0] lay);
		@(negedge clk);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			sprite_in.valid = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		sprite_in.valid = 1'b1;
		sprite_in.func = f;
		sprite_in.image_x = x;
		sprite_in.image_y = y;
		sprite_in.image_handle = h;
		sprite_in.layer = lay;
		do @(posedge clk); while (!sprite_in.ready);
	endtask

	task automatic add_sprite(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
			logic [HANDLE_W-1:0] h, logic [LAYER_W-1:0] lay);
		send_item(FUNC_ADD, x, y, h, lay);
	endtask

	// Payload of a draw is ignored; fill it with noise
	task automatic draw_frame();
		send_item(FUNC_DRAW, $urandom, $urandom, 16'($urandom), 8'($urandom));
	endtask

	// Drop valid, drain all results, then let an unfinished add complete
	task automatic settle();
		@(negedge clk);
		sprite_in.valid = 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		reg_writes++;
	endtask

	task automatic set_view(logic signed [COORD_W-1:0] left, logic signed [COORD_W-1:0] top,
			logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic [LCOUNT_W-1:0] n);
		write_reg(REG_VIEW_LEFT, left);
		write_reg(REG_VIEW_TOP, top);
		write_reg(REG_VIEW_WIDTH, {16'd0, w});
		write_reg(REG_VIEW_HEIGHT, {16'd0, h});
		write_reg(REG_LAYERS, {27'd0, n});
	endtask

	// Reset view: a zero-size window at the origin, one layer
	task automatic test_reset_view();
		draw_frame();
		add_sprite(32'sd0, 32'sd0, 16'h1234, 8'd0);
		add_sprite(32'sd1, 32'sd0, 16'hBEEF, 8'd3);
		add_sprite(32'sd0, -32'sd1, 16'h0F0F, 8'd1);
		draw_frame();
		settle();
	endtask

	// Sprites exactly on and just past each edge of the culling window
	task automatic test_window_edges();
		set_view(32'sd1000, -32'sd500, 16'd40, 16'd30, 5'd4);
		add_sprite(32'sd960, -32'sd500, 16'hFFFF, 8'd4);
		add_sprite(32'sd1080, -32'sd440, 16'h0000, 8'd1);
		add_sprite(32'sd959, -32'sd500, 16'h0001, 8'd2);
		add_sprite(32'sd1081, -32'sd500, 16'h0002, 8'd3);
		add_sprite(32'sd1000, -32'sd530, 16'h8000, 8'd255);
		add_sprite(32'sd1000, -32'sd439, 16'h7FFF, 8'd0);
		add_sprite(32'sd1000, -32'sd531, 16'h5555, 8'd2);
		draw_frame();
		settle();
	endtask

	// Window reaching past the 32-bit range at both ends
	task automatic test_coordinate_extremes();
		set_view(S32_TOP, S32_BOTTOM, 16'hFFFF, 16'hFFFF, 5'd16);
		add_sprite(S32_TOP, S32_BOTTOM, 16'hAAAA, 8'd16);
		add_sprite(S32_BOTTOM, S32_TOP, 16'h5555, 8'd1);
		add_sprite(S32_TOP - 32'sd65535, S32_BOTTOM + 32'sd131070, 16'h00FF, 8'd9);
		draw_frame();
		settle();
		set_view(S32_BOTTOM, S32_TOP, 16'hFFFF, 16'hFFFF, 5'd16);
		add_sprite(S32_BOTTOM, S32_TOP, 16'hFF00, 8'd2);
		add_sprite(S32_BOTTOM + 32'sd131070, S32_TOP - 32'sd65535, 16'h3C3C, 8'd1);
		draw_frame();
		settle();
	endtask

	// Layer count zero, above the maximum, and lowered between add and draw
	task automatic test_layer_clamping();
		set_view(32'sd0, 32'sd0, 16'hFFFF, 16'hFFFF, 5'd0);
		add_sprite(32'sd10, 32'sd20, 16'h0101, 8'd5);
		add_sprite(32'sd11, 32'sd21, 16'h0202, 8'd0);
		draw_frame();
		settle();
		write_reg(REG_LAYERS, 32'd31);
		add_sprite(32'sd1, 32'sd1, 16'h0303, 8'd255);
		add_sprite(32'sd2, 32'sd2, 16'h0404, 8'd17);
		add_sprite(32'sd3, 32'sd3, 16'h0505, 8'd1);
		draw_frame();
		settle();
		write_reg(REG_LAYERS, 32'd16);
		add_sprite(32'sd4, 32'sd4, 16'h0606, 8'd16);
		add_sprite(32'sd5, 32'sd5, 16'h0707, 8'd8);
		add_sprite(32'sd6, 32'sd6, 16'h0808, 8'd1);
		settle();
		write_reg(REG_LAYERS, 32'd2);
		draw_frame();
		settle();
	endtask

	// Fill the store past its capacity; the extra adds are dropped
	task automatic test_store_overflow();
		set_view(32'sd0, 32'sd0, 16'hFFFF, 16'hFFFF, 5'd16);
		for (int i = 0; i < MAX_SPR + 2; i++)
			add_sprite(32'($urandom_range(0, 1000)), 32'($urandom_range(0, 1000)),
				16'(i), 8'($urandom_range(1, 16)));
		draw_frame();
		settle();
	endtask

	// Hold the result side while items keep coming, so the input stalls
	task automatic test_output_backpressure();
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 12; i++)
			add_sprite(32'($urandom_range(0, 500)), 32'($urandom_range(0, 500)),
				16'($urandom), 8'($urandom_range(0, 18)));
		draw_frame();
		for (int i = 0; i < 4; i++)
			add_sprite(32'($urandom_range(0, 500)), 32'($urandom_range(0, 500)),
				16'($urandom), 8'($urandom_range(0, 18)));
		draw_frame();
		settle();
	endtask

	function automatic logic signed [COORD_W-1:0] pick_origin();
		case ($urandom_range(0, 5))
			0: return S32_BOTTOM;
			1: return S32_TOP;
			2: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(1, 300));
		endcase
	endfunction

	function automatic logic [LCOUNT_W-1:0] pick_layer_count();
		case ($urandom_range(0, 5))
			0: return 5'd0;
			1: return 5'd1;
			2: return 5'd16;
			3: return 5'($urandom_range(17, 31));
			default: return 5'($urandom_range(2, 15));
		endcase
	endfunction

	// Coordinate around the window, often right on an edge
	function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] org,
			logic [SIZE_W-1:0] span);
		longint o, s;
		o = longint'(org);
		s = longint'(span);
		case ($urandom_range(0, 9))
			0: return clamp32(o - s);
			1: return clamp32(o + 2 * s);
			2: return clamp32(o - s - 1);
			3: return clamp32(o + 2 * s + 1);
			4: return $urandom;
			default: return clamp32(o - s - 4 + longint'($urandom_range(0, 4 * span + 8)));
		endcase
	endfunction

	// Random frames of adds then a draw, one setting per idling mix
	task automatic test_random_traffic();
		int unsigned idle_mix[4]  = '{0, 71, 0, 24};
		int unsigned stall_mix[4] = '{0, 0, 71, 24};
		int          sent, nadd;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_mix[p];
			recv_stall_pct = stall_mix[p];
			set_view(pick_origin(), pick_origin(), pick_size(), pick_size(), pick_layer_count());
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				nadd = $urandom_range(0, 9);
				if (sent + nadd + 1 > PHASE_ITEMS) nadd = PHASE_ITEMS - sent - 1;
				repeat (nadd)
					add_sprite(near_coord(view_left_q, view_width_q),
						near_coord(view_top_q, view_height_q), 16'($urandom),
						($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 18)));
				draw_frame();
				sent += nadd + 1;
			end
			settle();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sprite_in.valid = 1'b0;
		sprite_in.func = FUNC_ADD;
		sprite_in.image_x = '0;
		sprite_in.image_y = '0;
		sprite_in.image_handle = '0;
		sprite_in.layer = '0;
		frame_out.ready = 1'b0;
		view_left_q = '0;
		view_top_q = '0;
		view_width_q = '0;
		view_height_q = '0;
		layer_count_q = 5'd1;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		hold_left = 0;
		items_taken = 0;
		draws_taken = 0;
		results_seen = 0;
		markers_seen = 0;
		reg_writes = 0;
		failures = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_view();
		test_window_edges();
		test_coordinate_extremes();
		test_layer_clamping();
		test_store_overflow();
		test_output_backpressure();
		test_random_traffic();

		settle();
		if (pending_frames.size() != 0) begin
			failures += pending_frames.size();
			$display("%0d expected results never arrived", pending_frames.size());
		end
		$display("covered %0d items (%0d draws), %0d results checked, %0d empty frames",
			items_taken, draws_taken, results_seen, markers_seen);
		$display("%0d register writes, store overflow, layer clamping and a %0d-cycle hold-off",
			reg_writes, HOLD_CYCLES);
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches in total", failures);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
